// ===== sv/spi_master_byte_transfer_defines.svh =====
// ----------------------------------------------------------------------------
// spi master byte transfer assertion macros
// shared property templates for the port checker
// ----------------------------------------------------------------------------
`ifndef SPI_MASTER_BYTE_TRANSFER_DEFINES_SVH
`define SPI_MASTER_BYTE_TRANSFER_DEFINES_SVH

// same-cycle implication, off during reset
`define SMB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spi master check failed");

// next-cycle implication, off during reset
`define SMB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spi master check failed");

`endif

// ===== sv/spi_mbt_pkg.sv =====
// ----------------------------------------------------------------------------
// spi master byte transfer package
// register indexes, microcode word layout and the sequencer program
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spi_mbt_pkg;

  localparam int unsigned WaitBitsDef = 16;
  localparam int unsigned PcW = 4;
  localparam int unsigned BitCntW = 4;
  localparam logic [BitCntW-1:0] BitsPerByte = BitCntW'(8);
  localparam logic [BitCntW-1:0] LastBit = BitCntW'(7);

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_SPI_MODE   = 1'b0,
    REG_PHASE_WAIT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_EMIT = 2'd0,
    OP_BR   = 2'd1,
    OP_END  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_OPEN     = 3'd1,
    C_CPHA     = 3'd2,
    C_MORE     = 3'd3,
    C_NOT_LAST = 3'd4
  } cond_e;

  typedef enum logic [1:0] {
    F_NO     = 2'd0,
    F_BITEND = 2'd1,
    F_ALWAYS = 2'd2
  } fin_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           cs;       // chip select level
    logic           clk_act;  // 1: active clock level, 0: idle level
    logic           mosi_bit; // 1: current tx bit, 0: held level
    logic           smp;      // miso sampled in this phase
    logic           adv;      // advance to the next bit afterwards
    fin_e           fin;
  } uword_t;

  function automatic uword_t mk(op_e op, cond_e cond, logic [PcW-1:0] target,
                                logic cs, logic clk_act, logic mosi_bit,
                                logic smp, logic adv, fin_e fin);
    uword_t w;
    w.op       = op;
    w.cond     = cond;
    w.target   = target;
    w.cs       = cs;
    w.clk_act  = clk_act;
    w.mosi_bit = mosi_bit;
    w.smp      = smp;
    w.adv      = adv;
    w.fin      = fin;
    return w;
  endfunction

  // sequencer program
  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      // frame already open: skip idle and select phases
      4'd0:    w = mk(OP_BR,   C_OPEN,     4'd3,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, F_NO);
      4'd1:    w = mk(OP_EMIT, C_ALWAYS,   4'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, F_NO);
      4'd2:    w = mk(OP_EMIT, C_ALWAYS,   4'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, F_NO);
      4'd3:    w = mk(OP_BR,   C_CPHA,     4'd9,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, F_NO);
      // cpha 0 bit: data, active clock with sample, idle clock
      4'd4:    w = mk(OP_EMIT, C_ALWAYS,   4'd0,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0, F_NO);
      4'd5:    w = mk(OP_EMIT, C_ALWAYS,   4'd0,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0, F_NO);
      4'd6:    w = mk(OP_EMIT, C_ALWAYS,   4'd0,  1'b0, 1'b0, 1'b1, 1'b0, 1'b1, F_BITEND);
      4'd7:    w = mk(OP_BR,   C_MORE,     4'd4,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, F_NO);
      4'd8:    w = mk(OP_BR,   C_ALWAYS,   4'd13, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, F_NO);
      // cpha 1 bit: active clock with old data, new data, idle clock with sample
      4'd9:    w = mk(OP_EMIT, C_ALWAYS,   4'd0,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, F_NO);
      4'd10:   w = mk(OP_EMIT, C_ALWAYS,   4'd0,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0, F_NO);
      4'd11:   w = mk(OP_EMIT, C_ALWAYS,   4'd0,  1'b0, 1'b0, 1'b1, 1'b1, 1'b1, F_BITEND);
      4'd12:   w = mk(OP_BR,   C_MORE,     4'd9,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, F_NO);
      4'd13:   w = mk(OP_BR,   C_NOT_LAST, 4'd15, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, F_NO);
      4'd14:   w = mk(OP_EMIT, C_ALWAYS,   4'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, F_ALWAYS);
      default: w = mk(OP_END,  C_ALWAYS,   4'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, F_NO);
    endcase
    return w;
  endfunction

endpackage

// ===== sv/spi_master_byte_transfer.sv =====
// ----------------------------------------------------------------------------
// spi master byte transfer
// spi master, modes 0 to 3, msb first, one byte per item, driven by microcode
// ----------------------------------------------------------------------------
// Each accepted item produces 24 to 27 wire-phase results: idle and select
// phases when no frame is open, three phases per bit, and a deselect phase
// when the item ends the frame. Each phase is issued by an emit word and
// stays on the result port until it is taken, held while out_stall_i is set,
// then the block counts down phase_wait (low WAIT_BITS bits) before the next
// step. Between the emit words the microcode sequencer also steps through
// the branch words and the end word; a new item is taken only once the
// previous one has run its whole program.
`timescale 1ns / 1ps

module spi_master_byte_transfer #(
  parameter int unsigned WAIT_BITS = spi_mbt_pkg::WaitBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  spi_mbt_pkg::reg_idx_e     cfg_idx_i,
  input  logic [15:0]               cfg_data_i,
  // input items
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                tx_byte_i,
  input  logic [7:0]                miso_bits_i,
  input  logic                      last_of_frame_i,
  // result items
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      cs_n_o,
  output logic                      sclk_o,
  output logic                      mosi_level_o,
  output logic                      sampled_o,
  output logic [7:0]                rx_byte_o,
  output logic                      last_o
);

  import spi_mbt_pkg::*;

  logic [1:0]           spi_mode_q;
  logic [15:0]          phase_wait_q;
  logic                 busy_q;
  logic [PcW-1:0]       pc_q;
  logic [BitCntW-1:0]   bit_q;
  logic [WAIT_BITS-1:0] wait_q;
  logic                 frame_open_q;
  logic                 mosi_held_q;
  logic [7:0]           tx_q;
  logic [7:0]           miso_q;
  logic [7:0]           rx_q;
  logic                 last_q;
  logic                 out_valid_q;
  logic                 cs_n_q, sclk_q, mosi_q, smp_q, fin_q;
  logic [7:0]           rx_out_q;

  uword_t     uw;
  logic       cond_ok;
  logic       step;
  logic       in_acc;
  logic       out_acc;
  logic       cpol;
  logic       bit_val;
  logic [7:0] rx_next;
  logic       fin_now;

  assign uw      = ucode(pc_q);
  assign cpol    = spi_mode_q[1];
  assign in_acc  = in_valid_i && !busy_q;
  assign out_acc = out_valid_q && !out_stall_i;
  assign step    = busy_q && !out_valid_q && (wait_q == '0);
  assign bit_val = tx_q[7];
  assign rx_next = uw.smp ? {rx_q[6:0], miso_q[7]} : rx_q;

  always_comb begin
    case (uw.cond)
      C_ALWAYS:   cond_ok = 1'b1;
      C_OPEN:     cond_ok = frame_open_q;
      C_CPHA:     cond_ok = spi_mode_q[0];
      C_MORE:     cond_ok = (bit_q != BitsPerByte);
      C_NOT_LAST: cond_ok = !last_q;
      default:    cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.fin)
      F_BITEND: fin_now = (bit_q == LastBit) && !last_q;
      F_ALWAYS: fin_now = 1'b1;
      default:  fin_now = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spi_mode_q   <= '0;
      phase_wait_q <= '0;
      busy_q       <= 1'b0;
      pc_q         <= '0;
      bit_q        <= '0;
      wait_q       <= '0;
      frame_open_q <= 1'b0;
      mosi_held_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SPI_MODE:   spi_mode_q   <= cfg_data_i[1:0];
          REG_PHASE_WAIT: phase_wait_q <= cfg_data_i;
          default:        ;
        endcase
      end

      if (out_acc) begin
        out_valid_q <= 1'b0;
        wait_q      <= WAIT_BITS'(phase_wait_q);
      end else if (wait_q != '0) begin
        wait_q <= wait_q - 1'b1;
      end

      if (in_acc) begin
        busy_q <= 1'b1;
        pc_q   <= '0;
        bit_q  <= '0;
      end else if (step) begin
        case (uw.op)
          OP_BR: begin
            pc_q <= cond_ok ? uw.target : pc_q + 1'b1;
          end
          OP_EMIT: begin
            pc_q         <= pc_q + 1'b1;
            out_valid_q  <= 1'b1;
            frame_open_q <= !uw.cs;
            if (uw.mosi_bit) mosi_held_q <= bit_val;
            if (uw.adv) bit_q <= bit_q + 1'b1;
          end
          default: begin
            busy_q <= 1'b0;
          end
        endcase
      end
    end
  end

  // datapath and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tx_q   <= tx_byte_i;
      miso_q <= miso_bits_i;
      last_q <= last_of_frame_i;
      rx_q   <= '0;
    end else if (step && uw.op == OP_EMIT) begin
      cs_n_q   <= uw.cs;
      sclk_q   <= uw.clk_act ? !cpol : cpol;
      mosi_q   <= uw.mosi_bit ? bit_val : mosi_held_q;
      smp_q    <= uw.smp;
      fin_q    <= fin_now;
      rx_out_q <= fin_now ? rx_next : 8'h00;
      rx_q     <= rx_next;
      if (uw.smp) miso_q <= {miso_q[6:0], 1'b0};
      if (uw.adv) tx_q <= {tx_q[6:0], 1'b0};
    end
  end

  assign in_stall_o   = busy_q;
  assign out_valid_o  = out_valid_q;
  assign cs_n_o       = cs_n_q;
  assign sclk_o       = sclk_q;
  assign mosi_level_o = mosi_q;
  assign sampled_o    = smp_q;
  assign rx_byte_o    = rx_out_q;
  assign last_o       = fin_q;

endmodule

// ===== sv/spi_mbt_checker.sv =====
// ----------------------------------------------------------------------------
// spi master byte transfer port checker
// checks result channel behavior seen at the top level ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spi_master_byte_transfer_defines.svh"

module spi_mbt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       cs_n_o,
  input logic       sampled_o,
  input logic [7:0] rx_byte_o,
  input logic       last_o
);

  // a stalled result holds
  `SMB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(rx_byte_o) && $stable(last_o))
  // ready for a new item only with no result pending
  `SMB_ASSERT_IMPL(a_idle_empty, !in_stall_o, !out_valid_o)
  // received byte shows only on the final phase
  `SMB_ASSERT_IMPL(a_rx_final, out_valid_o && !last_o, rx_byte_o == 8'h00)
  // no sampling while deselected
  `SMB_ASSERT_IMPL(a_no_smp_cs, out_valid_o && cs_n_o, !sampled_o)

endmodule

bind spi_master_byte_transfer spi_mbt_checker u_spi_mbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .cs_n_o      (cs_n_o),
  .sampled_o   (sampled_o),
  .rx_byte_o   (rx_byte_o),
  .last_o      (last_o)
);
